// File: design/tile_grid_box_collision_macros.svh
// assertion macros for the tile grid box collision block
`ifndef TILE_GRID_BOX_COLLISION_MACROS_SVH
`define TILE_GRID_BOX_COLLISION_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define TGBC_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TGBC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TGBC_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define TGBC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: design/tgbc_pkg.sv
`default_nettype none

package tgbc_pkg;

  // field and datapath widths
  localparam int unsigned TS_W        = 7;
  localparam int unsigned MW_W        = 13;
  localparam int unsigned ADDR_IN_W   = 12;
  localparam int unsigned POS_W       = 14;
  localparam int unsigned SIZE_W      = 11;
  localparam int unsigned COORD_W     = 15;
  localparam int unsigned IDX_W       = 28;
  localparam int unsigned PROD_W      = 22;
  localparam int unsigned DIFF_W      = 23;
  localparam int unsigned NUM_LANES   = 4;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  // register reset values
  localparam logic [TS_W-1:0] TS_RESET = 7'd16;
  localparam logic [MW_W-1:0] MW_RESET = 13'd64;

  // saturation bounds of the corrected coordinates
  localparam logic signed [DIFF_W-1:0] SAT_HI = 23'sd16383;
  localparam logic signed [DIFF_W-1:0] SAT_LO = -23'sd16384;

  // divider lanes
  localparam int unsigned LANE_LEFT   = 0;
  localparam int unsigned LANE_RIGHT  = 1;
  localparam int unsigned LANE_TOP    = 2;
  localparam int unsigned LANE_BOTTOM = 3;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_HORIZ  = 2'd1,
    OP_VERT   = 2'd2,
    OP_GROUND = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    REG_TILE_SIZE = 1'b0,
    REG_MAP_WIDTH = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_BASE,
    ST_ISSUE,
    ST_CHECK,
    ST_CORR,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_en;
    logic mem_wr;
    logic load;
    logic div_step;
    logic base;
    logic rd_en;
    logic advance;
    logic set_hit;
    logic corr;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic tile_ok;
    logic rd_solid;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: design/tgbc_div.sv
`default_nettype none

// four-lane restoring divider, one quotient bit per lane per step
module tgbc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          step,
  input  tgbc_pkg::coord_t              dividend [tgbc_pkg::NUM_LANES],
  input  logic [tgbc_pkg::TS_W-1:0]     divisor,
  output tgbc_pkg::coord_t              quot     [tgbc_pkg::NUM_LANES],
  output logic [tgbc_pkg::TS_W-1:0]     rem      [tgbc_pkg::NUM_LANES],
  output logic                          last
);

  localparam int QW = tgbc_pkg::COORD_W;
  localparam int TW = tgbc_pkg::TS_W;
  localparam int NL = tgbc_pkg::NUM_LANES;
  localparam int CW = $clog2(QW);

  tgbc_pkg::coord_t q_r   [NL];
  tgbc_pkg::coord_t q_nxt [NL];
  logic [TW-1:0]    rem_r   [NL];
  logic [TW-1:0]    rem_nxt [NL];
  logic [TW:0]      partial [NL];
  logic [CW-1:0]    cnt_r;

  // one shift-subtract step in every lane
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      partial[l] = {rem_r[l], q_r[l][QW-1]};
      if (partial[l] >= {1'b0, divisor}) begin
        rem_nxt[l] = TW'(partial[l] - {1'b0, divisor});
        q_nxt[l]   = {q_r[l][QW-2:0], 1'b1};
      end else begin
        rem_nxt[l] = partial[l][TW-1:0];
        q_nxt[l]   = {q_r[l][QW-2:0], 1'b0};
      end
    end
  end

  // quotient and remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '{default: '0};
    end else if (step) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign quot = q_r;
  assign rem  = rem_r;
  assign last = (cnt_r == CW'(QW - 1));

endmodule

`default_nettype wire

// File: design/tgbc_dp.sv
`default_nettype none

// datapath: tile map, divider, edge walk, correction and output register
module tgbc_dp #(
  parameter int MAX_TILES = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tgbc_pkg::cmd_t                    cmd,
  output tgbc_pkg::stat_t                   stat,
  input  tgbc_pkg::op_t                     opcode,
  input  logic [tgbc_pkg::ADDR_IN_W-1:0]    tile_addr,
  input  logic                              tile_solid,
  input  logic [tgbc_pkg::POS_W-1:0]        pos_x,
  input  logic [tgbc_pkg::POS_W-1:0]        pos_y,
  input  logic [tgbc_pkg::SIZE_W-1:0]       size_x,
  input  logic [tgbc_pkg::SIZE_W-1:0]       size_y,
  input  logic                              moving_positive,
  input  logic [tgbc_pkg::TS_W-1:0]         tile_size,
  input  logic [tgbc_pkg::MW_W-1:0]         map_width,
  output logic                              hit,
  output logic [tgbc_pkg::COORD_W-1:0]      new_x,
  output logic [tgbc_pkg::COORD_W-1:0]      new_y,
  output logic                              out_valid,
  input  logic                              out_ready
);

  localparam int AW = $clog2(MAX_TILES);
  localparam int IW = tgbc_pkg::IDX_W;
  localparam int QW = tgbc_pkg::COORD_W;
  localparam int TW = tgbc_pkg::TS_W;
  localparam int SW = tgbc_pkg::SIZE_W;
  localparam int PW = tgbc_pkg::POS_W;
  localparam int NL = tgbc_pkg::NUM_LANES;
  localparam int DW = tgbc_pkg::DIFF_W;
  localparam int XW = tgbc_pkg::PROD_W;
  localparam logic [IW-1:0] MAX_IDX = IW'(MAX_TILES);

  // tile map and sweep counter
  logic              solid_map_r [MAX_TILES];
  logic [AW-1:0]     clr_cnt_r;
  logic              rd_data_r;
  logic              wr_in_range;

  // captured item
  tgbc_pkg::op_t     op_r;
  logic [PW-1:0]     px_r;
  logic [PW-1:0]     py_r;
  logic [SW-1:0]     sx_r;
  logic [SW-1:0]     sy_r;
  logic              pos_r;
  logic [TW-1:0]     ts_r;
  logic              hit_r;
  logic [SW-1:0]     sx_eff;
  logic [SW-1:0]     sy_eff;

  // divider
  tgbc_pkg::coord_t  dividend [NL];
  tgbc_pkg::coord_t  quot     [NL];
  logic [TW-1:0]     rem      [NL];
  logic              div_last;
  tgbc_pkg::coord_t  ground_row;

  // walk
  tgbc_pkg::coord_t  row_sel;
  tgbc_pkg::coord_t  col_sel;
  tgbc_pkg::coord_t  end_sel;
  logic [IW-1:0]     idx_r;
  tgbc_pkg::coord_t  i_r;
  tgbc_pkg::coord_t  end_r;
  tgbc_pkg::coord_t  col_r;
  logic              step_x_r;
  tgbc_pkg::coord_t  cur_col;

  // correction
  tgbc_pkg::coord_t  qsel;
  logic [XW-1:0]     prod_r;
  logic [SW-1:0]     sub_r;
  logic signed [DW-1:0] diff;
  logic [QW-1:0]     sat_val;

  // output register
  logic              out_valid_r;
  logic              out_hit_r;
  logic [QW-1:0]     out_x_r;
  logic [QW-1:0]     out_y_r;

  assign sx_eff      = (size_x == '0) ? SW'(1) : size_x;
  assign sy_eff      = (size_y == '0) ? SW'(1) : size_y;
  assign wr_in_range = ({20'b0, tile_addr} < 32'(MAX_TILES));

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // map write port
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      solid_map_r[clr_cnt_r] <= 1'b0;
    end else if (cmd.mem_wr && wr_in_range) begin
      solid_map_r[AW'(tile_addr)] <= tile_solid;
    end
  end

  // map read port
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= solid_map_r[idx_r[AW-1:0]];
    end
  end

  // capture the query item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= opcode;
      px_r  <= pos_x;
      py_r  <= pos_y;
      sx_r  <= sx_eff;
      sy_r  <= sy_eff;
      pos_r <= moving_positive;
      ts_r  <= (tile_size == '0) ? TW'(1) : tile_size;
    end
  end

  // hit flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.load) begin
      hit_r <= 1'b0;
    end else if (cmd.set_hit) begin
      hit_r <= 1'b1;
    end
  end

  // box edges to divide
  always_comb begin
    dividend[tgbc_pkg::LANE_LEFT]   = {1'b0, pos_x};
    dividend[tgbc_pkg::LANE_RIGHT]  = {1'b0, pos_x} + {4'b0, sx_eff} - QW'(1);
    dividend[tgbc_pkg::LANE_TOP]    = {1'b0, pos_y};
    dividend[tgbc_pkg::LANE_BOTTOM] = {1'b0, pos_y} + {4'b0, sy_eff} - QW'(1);
  end

  tgbc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.load),
    .step     (cmd.div_step),
    .dividend (dividend),
    .divisor  (ts_r),
    .quot     (quot),
    .rem      (rem),
    .last     (div_last)
  );

  // row just below the box: one past bottom when bottom edge ends a tile
  assign ground_row = quot[tgbc_pkg::LANE_BOTTOM]
                    + {{(QW-1){1'b0}}, (rem[tgbc_pkg::LANE_BOTTOM] == (ts_r - TW'(1)))};

  // walk setup per query kind
  always_comb begin
    case (op_r)
      tgbc_pkg::OP_HORIZ: begin
        row_sel = quot[tgbc_pkg::LANE_TOP];
        col_sel = pos_r ? quot[tgbc_pkg::LANE_RIGHT] : quot[tgbc_pkg::LANE_LEFT];
        end_sel = quot[tgbc_pkg::LANE_BOTTOM];
      end
      tgbc_pkg::OP_VERT: begin
        row_sel = pos_r ? quot[tgbc_pkg::LANE_BOTTOM] : quot[tgbc_pkg::LANE_TOP];
        col_sel = quot[tgbc_pkg::LANE_LEFT];
        end_sel = quot[tgbc_pkg::LANE_RIGHT];
      end
      default: begin
        row_sel = ground_row;
        col_sel = quot[tgbc_pkg::LANE_LEFT];
        end_sel = quot[tgbc_pkg::LANE_RIGHT];
      end
    endcase
  end

  // walk registers: linear index, loop counter and bound
  always_ff @(posedge clk) begin
    if (cmd.base) begin
      idx_r    <= ({13'b0, row_sel} * {15'b0, map_width}) + {13'b0, col_sel};
      i_r      <= (op_r == tgbc_pkg::OP_HORIZ) ? quot[tgbc_pkg::LANE_TOP] : col_sel;
      end_r    <= end_sel;
      col_r    <= col_sel;
      step_x_r <= (op_r == tgbc_pkg::OP_HORIZ);
    end else if (cmd.advance) begin
      idx_r <= idx_r + (step_x_r ? {15'b0, map_width} : IW'(1));
      i_r   <= i_r + QW'(1);
    end
  end

  // tile inside the map and walk not finished
  assign cur_col = step_x_r ? col_r : i_r;

  // coordinate correction: tile edge times tile size
  always_comb begin
    case (op_r)
      tgbc_pkg::OP_HORIZ: qsel = pos_r ? quot[tgbc_pkg::LANE_RIGHT]
                                       : quot[tgbc_pkg::LANE_LEFT] + QW'(1);
      default:            qsel = pos_r ? quot[tgbc_pkg::LANE_BOTTOM]
                                       : quot[tgbc_pkg::LANE_TOP] + QW'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.corr) begin
      prod_r <= {15'b0, ts_r} * {7'b0, qsel};
      sub_r  <= pos_r ? ((op_r == tgbc_pkg::OP_HORIZ) ? sx_r : sy_r) : '0;
    end
  end

  // subtract and saturate
  always_comb begin
    diff = signed'({1'b0, prod_r}) - signed'({12'b0, sub_r});
    if (diff > tgbc_pkg::SAT_HI) begin
      sat_val = tgbc_pkg::SAT_HI[QW-1:0];
    end else if (diff < tgbc_pkg::SAT_LO) begin
      sat_val = tgbc_pkg::SAT_LO[QW-1:0];
    end else begin
      sat_val = diff[QW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_hit_r <= hit_r;
      out_x_r   <= (hit_r && op_r == tgbc_pkg::OP_HORIZ) ? sat_val : {1'b0, px_r};
      out_y_r   <= (hit_r && op_r == tgbc_pkg::OP_VERT)  ? sat_val : {1'b0, py_r};
    end
  end

  // status to the controller
  always_comb begin
    stat.clr_last = (clr_cnt_r == AW'(MAX_TILES - 1));
    stat.div_last = div_last;
    stat.tile_ok  = (cur_col < {2'b0, map_width}) && (idx_r < MAX_IDX) && (i_r <= end_r);
    stat.rd_solid = rd_data_r;
    stat.out_free = !out_valid_r || out_ready;
  end

  assign hit       = out_hit_r;
  assign new_x     = out_x_r;
  assign new_y     = out_y_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: design/tgbc_ctrl.sv
`default_nettype none

// sequencer: clear sweep, divide, edge walk, correction, result hand-off
module tgbc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_is_write,
  output logic             in_ready,
  input  tgbc_pkg::stat_t  stat,
  output tgbc_pkg::cmd_t   cmd
);

  tgbc_pkg::state_t state_r;
  tgbc_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tgbc_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tgbc_pkg::ST_CLEAR: if (stat.clr_last) state_nxt = tgbc_pkg::ST_IDLE;
      tgbc_pkg::ST_IDLE:  if (in_valid && !in_is_write) state_nxt = tgbc_pkg::ST_DIV;
      tgbc_pkg::ST_DIV:   if (stat.div_last) state_nxt = tgbc_pkg::ST_BASE;
      tgbc_pkg::ST_BASE:  state_nxt = tgbc_pkg::ST_ISSUE;
      tgbc_pkg::ST_ISSUE: begin
        state_nxt = stat.tile_ok ? tgbc_pkg::ST_CHECK : tgbc_pkg::ST_CORR;
      end
      tgbc_pkg::ST_CHECK: begin
        state_nxt = stat.rd_solid ? tgbc_pkg::ST_CORR : tgbc_pkg::ST_ISSUE;
      end
      tgbc_pkg::ST_CORR:  state_nxt = tgbc_pkg::ST_DONE;
      tgbc_pkg::ST_DONE:  if (stat.out_free) state_nxt = tgbc_pkg::ST_IDLE;
      default:            state_nxt = tgbc_pkg::ST_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      tgbc_pkg::ST_CLEAR: cmd.clr_en = 1'b1;
      tgbc_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.mem_wr = in_valid && in_is_write;
        cmd.load   = in_valid && !in_is_write;
      end
      tgbc_pkg::ST_DIV:   cmd.div_step = 1'b1;
      tgbc_pkg::ST_BASE:  cmd.base = 1'b1;
      tgbc_pkg::ST_ISSUE: cmd.rd_en = stat.tile_ok;
      tgbc_pkg::ST_CHECK: begin
        cmd.set_hit = stat.rd_solid;
        cmd.advance = !stat.rd_solid;
      end
      tgbc_pkg::ST_CORR:  cmd.corr = 1'b1;
      tgbc_pkg::ST_DONE:  cmd.load_out = stat.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/tile_grid_box_collision.sv
// Tile grid box collision: a one-bit solid map of tiles with box queries.
// Input channel (in_*): tuser carries the opcode. A write item loads one map
// entry and leaves in_tready high; it gives no result. A query item
// (horizontal, vertical or grounded) gives exactly one result item on out_*.
// Configuration (cfg_*): tile_size at byte 0, map_width at byte 4, to be written
// by the user only while the block is idle; the block does not enforce this.
// A query runs through the divider, then the walk along the leading edge, then
// the correction. The divider works out one quotient bit a step, all four box
// edges in parallel; the walk tests each tile in an issue state and a check
// state for the registered map read, and stops at the first solid tile.
// One query is worked on at a time; the next is accepted as soon as the
// previous result sits in the output register.
// Reset: the map is cleared by a sweep over all MAX_TILES entries, one entry a
// cycle; in_tready stays low until it is done. Config writes go through.
// A stalled receiver holds the result in the output register; a finished
// second query then waits until the first result is taken.
`default_nettype none
`include "tile_grid_box_collision_macros.svh"

module tile_grid_box_collision #(
  parameter int MAX_TILES = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: tile_addr, tile_solid, pos_x, pos_y, size_x, size_y,
  //           moving_positive
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [tgbc_pkg::IN_TDATA_W-1:0]       in_tdata,
  // in_tuser: opcode
  input  logic [1:0]                            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // out_tdata: hit, new_x, new_y, zero pad
  output logic [tgbc_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [tgbc_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [tgbc_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [tgbc_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                  cfg_pready
);

  logic [tgbc_pkg::TS_W-1:0]   tile_size_r;
  logic [tgbc_pkg::MW_W-1:0]   map_width_r;
  logic                        cfg_wr;
  tgbc_pkg::reg_idx_t          cfg_idx;
  tgbc_pkg::cmd_t              cmd;
  tgbc_pkg::stat_t             stat;
  tgbc_pkg::op_t               opcode;
  logic                        in_is_write;
  logic                        hit;
  logic [tgbc_pkg::COORD_W-1:0] new_x;
  logic [tgbc_pkg::COORD_W-1:0] new_y;
  logic                        in_acc;
  logic                        cfg_ts_wr;
  logic [tgbc_pkg::TS_W-1:0]   ts_wdata;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = tgbc_pkg::reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_size_r <= tgbc_pkg::TS_RESET;
      map_width_r <= tgbc_pkg::MW_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tgbc_pkg::REG_TILE_SIZE: tile_size_r <= cfg_pwdata[tgbc_pkg::TS_W-1:0];
        tgbc_pkg::REG_MAP_WIDTH: map_width_r <= cfg_pwdata[tgbc_pkg::MW_W-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (cfg_idx)
      tgbc_pkg::REG_TILE_SIZE: cfg_prdata = {25'b0, tile_size_r};
      tgbc_pkg::REG_MAP_WIDTH: cfg_prdata = {19'b0, map_width_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  assign opcode      = tgbc_pkg::op_t'(in_tuser);
  assign in_is_write = (opcode == tgbc_pkg::OP_WRITE);

  tgbc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_is_write (in_is_write),
    .in_ready    (in_tready),
    .stat        (stat),
    .cmd         (cmd)
  );

  tgbc_dp #(
    .MAX_TILES (MAX_TILES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .opcode          (opcode),
    .tile_addr       (in_tdata[11:0]),
    .tile_solid      (in_tdata[12]),
    .pos_x           (in_tdata[26:13]),
    .pos_y           (in_tdata[40:27]),
    .size_x          (in_tdata[51:41]),
    .size_y          (in_tdata[62:52]),
    .moving_positive (in_tdata[63]),
    .tile_size       (tile_size_r),
    .map_width       (map_width_r),
    .hit             (hit),
    .new_x           (new_x),
    .new_y           (new_y),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready)
  );

  assign out_tdata = {1'b0, new_y, new_x, hit};

  // handshake terms for the checks
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ts_wr = cfg_wr && (cfg_idx == tgbc_pkg::REG_TILE_SIZE);
  assign ts_wdata  = cfg_pwdata[tgbc_pkg::TS_W-1:0];

  // a query takes the block busy, a write leaves it ready
  `TGBC_ASSERT_NEXT(a_query_busy, clk, rst_n, in_acc && !in_is_write, !in_tready, "block still ready")
  `TGBC_ASSERT_NEXT(a_write_ready, clk, rst_n, in_acc && in_is_write, in_tready, "write stalled input")
  // config write lands in the tile size register
  `TGBC_ASSERT_NEXT(a_cfg_ts, clk, rst_n, cfg_ts_wr, tile_size_r == $past(ts_wdata), "tile size lost")
  // no map write while a query owns the map
  `TGBC_ASSERT_IMPL(a_wr_idle, clk, rst_n, cmd.mem_wr, !cmd.rd_en && !cmd.clr_en, "map write while busy")

endmodule

`default_nettype wire

// File: tb/sv/tb_tile_grid_box_collision.sv
`timescale 1ns / 100ps

module tb_tile_grid_box_collision;
  import tgbc_pkg::*;

  localparam int unsigned MAP_TILES = 4096;
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned END_CYCLES = 60;
  localparam int unsigned PHASE_ITEMS = 119;
  localparam int unsigned NUM_PHASES = 8;

  // one input item, split into its fields
  typedef struct packed {
    op_t         op;
    logic [11:0] addr;
    logic        solid;
    logic [13:0] px;
    logic [13:0] py;
    logic [10:0] sx;
    logic [10:0] sy;
    logic        pos;
  } box_item_t;

  // one result item
  typedef struct packed {
    logic   hit;
    coord_t nx;
    coord_t ny;
  } collision_t;

  // one row of the directed table: an item or a register write
  typedef struct packed {
    logic        is_cfg;
    reg_idx_t    reg_sel;
    logic [31:0] reg_val;
    box_item_t   item;
    logic        typed;
    collision_t  want;
  } step_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_ADDR_W-1:0]  cfg_paddr;
  logic [CFG_DATA_W-1:0]  cfg_pwdata;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  // predictor state
  bit                  tile_map_model [MAP_TILES];
  logic [TS_W-1:0]     ts_reg;
  logic [MW_W-1:0]     mw_reg;
  collision_t          pending_results [$];
  int unsigned         mismatch_cnt;
  int unsigned         idle_cycles;
  bit                  quiet;
  int unsigned         stall_left;

  // directed table
  step_row_t           dir_rows [$];

  tile_grid_box_collision dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mismatch reporting, first ten in full
  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("mismatch %0d at %0t: %s expected %0d got %0d", mismatch_cnt, $realtime, what,
               want, got);
    end
  endtask

  // append one row to the directed table
  task automatic add_row(input step_row_t row);
    dir_rows = {dir_rows, row};
  endtask

  // tdata: tile_addr, tile_solid, pos_x, pos_y, size_x, size_y, moving_positive
  function automatic logic [IN_TDATA_W-1:0] pack_item(box_item_t it);
    return {it.pos, it.sy, it.sx, it.py, it.px, it.solid, it.addr};
  endfunction

  function automatic coord_t clamp_coord(longint v);
    longint c;
    c = v;
    if (c > 16383) c = 16383;
    if (c < -16384) c = -16384;
    return c[COORD_W-1:0];
  endfunction

  // map lookup, anything outside the map is empty
  function automatic bit solid_at(longint unsigned col, longint unsigned row);
    longint unsigned idx;
    if (col >= longint'(mw_reg)) return 1'b0;
    idx = row * mw_reg + col;
    if (idx >= MAP_TILES) return 1'b0;
    return tile_map_model[idx];
  endfunction

  // expected result of one query
  function automatic collision_t predict_collision(box_item_t it);
    longint unsigned ts, sx, sy, lft, rgt, top, bot, line, i;
    longint nx, ny;
    logic hit;
    collision_t r;
    ts = (ts_reg == 0) ? 1 : ts_reg;
    sx = (it.sx == 0) ? 1 : it.sx;
    sy = (it.sy == 0) ? 1 : it.sy;
    lft = it.px / ts;
    rgt = (it.px + sx - 1) / ts;
    top = it.py / ts;
    bot = (it.py + sy - 1) / ts;
    nx = it.px;
    ny = it.py;
    hit = 1'b0;
    case (it.op)
      OP_HORIZ: begin
        line = it.pos ? rgt : lft;
        for (i = top; i <= bot && !hit; i++) hit = solid_at(line, i);
        if (hit) nx = it.pos ? longint'(ts * rgt) - longint'(sx) : longint'(ts * (lft + 1));
      end
      OP_VERT: begin
        line = it.pos ? bot : top;
        for (i = lft; i <= rgt && !hit; i++) hit = solid_at(i, line);
        if (hit) ny = it.pos ? longint'(ts * bot) - longint'(sy) : longint'(ts * (top + 1));
      end
      default: begin
        line = (it.py + sy) / ts;
        for (i = lft; i <= rgt && !hit; i++) hit = solid_at(i, line);
      end
    endcase
    r.hit = hit;
    r.nx = clamp_coord(nx);
    r.ny = clamp_coord(ny);
    return r;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [10:0] pick_size(int unsigned ts);
    int unsigned r, cap;
    r = $urandom_range(0, 99);
    cap = 3 * ts;
    if (cap > 2047) cap = 2047;
    if (r < 5) return 11'd0;
    if (r < 9) return 11'($urandom_range(0, 2047));
    return 11'($urandom_range(1, cap));
  endfunction

  // random item, queries mostly placed over the map area
  function automatic box_item_t gen_item();
    box_item_t it;
    int unsigned ts, mw, rows, xs, ys;
    ts = (ts_reg == 0) ? 1 : ts_reg;
    mw = (mw_reg == 0) ? 1 : mw_reg;
    rows = MAP_TILES / mw;
    if (rows == 0) rows = 1;
    xs = ts * mw + 2 * ts;
    if (xs > 16383) xs = 16383;
    ys = ts * rows + 2 * ts;
    if (ys > 16383) ys = 16383;
    it.addr = 12'($urandom);
    it.solid = 1'($urandom);
    it.px = 14'($urandom);
    it.py = 14'($urandom);
    it.sx = 11'($urandom);
    it.sy = 11'($urandom);
    it.pos = 1'($urandom);
    if ($urandom_range(0, 99) < 30) begin
      it.op = OP_WRITE;
      it.solid = ($urandom_range(0, 99) < 40);
    end else begin
      it.op = op_t'($urandom_range(1, 3));
      if ($urandom_range(0, 4) != 0) begin
        it.px = 14'($urandom_range(0, xs));
        it.py = 14'($urandom_range(0, ys));
      end
      it.sx = pick_size(ts);
      it.sy = pick_size(ts);
    end
    return it;
  endfunction

  function automatic step_row_t mk_item(op_t op, int unsigned addr, bit solid, int unsigned px,
                                        int unsigned py, int unsigned sx, int unsigned sy,
                                        bit pos);
    step_row_t row;
    row = '0;
    row.item.op = op;
    row.item.addr = addr[11:0];
    row.item.solid = solid;
    row.item.px = px[13:0];
    row.item.py = py[13:0];
    row.item.sx = sx[10:0];
    row.item.sy = sy[10:0];
    row.item.pos = pos;
    return row;
  endfunction

  function automatic step_row_t mk_cfg(reg_idx_t sel, int unsigned val);
    step_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  function automatic step_row_t known(step_row_t row, bit hit, int unsigned nx, int unsigned ny);
    step_row_t r;
    r = row;
    r.typed = 1'b1;
    r.want.hit = hit;
    r.want.nx = nx[COORD_W-1:0];
    r.want.ny = ny[COORD_W-1:0];
    return r;
  endfunction

  // send one item; entered and left at a falling edge
  task automatic push_item(input box_item_t it, input logic typed, input collision_t want);
    int unsigned n;
    collision_t r;
    n = gap_len();
    if (n > 0) begin
      in_tvalid = 1'b0;
      repeat (n) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = pack_item(it);
    in_tuser = it.op;
    do @(posedge clk); while (!in_tready);
    if (it.op == OP_WRITE) begin
      tile_map_model[it.addr] = it.solid;
    end else begin
      r = typed ? want : predict_collision(it);
      pending_results = {pending_results, r};
    end
    @(negedge clk);
  endtask

  // wait until the block is idle
  task automatic settle();
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write followed by a read back
  task automatic write_reg(input reg_idx_t sel, input logic [31:0] val);
    logic [31:0] rd;
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {sel, 2'b00};
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (sel == REG_TILE_SIZE) ts_reg = val[TS_W-1:0];
    else mw_reg = val[MW_W-1:0];
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    if (sel == REG_TILE_SIZE) begin
      if (rd[TS_W-1:0] !== ts_reg) note_mismatch("tile_size read", ts_reg, rd[TS_W-1:0]);
    end else begin
      if (rd[MW_W-1:0] !== mw_reg) note_mismatch("map_width read", mw_reg, rd[MW_W-1:0]);
    end
  endtask

  // receiver stalls
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  // result checking
  always @(posedge clk) begin : out_check
    collision_t want;
    logic hit;
    coord_t nx, ny;
    if (rst_n && out_tvalid && out_tready) begin
      hit = out_tdata[0];
      nx = out_tdata[15:1];
      ny = out_tdata[30:16];
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected item, hit", -1, hit);
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit) note_mismatch("hit", want.hit, hit);
        if (nx !== want.nx) note_mismatch("new_x", $signed(want.nx), $signed(nx));
        if (ny !== want.ny) note_mismatch("new_y", $signed(want.ny), $signed(ny));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[tile_grid_box_collision] ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned phase_ts [NUM_PHASES];
    int unsigned phase_mw [NUM_PHASES];
    collision_t  none;
    int unsigned p, k;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_WRITE;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatch_cnt = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    ts_reg = TS_RESET;
    mw_reg = MW_RESET;
    none = '0;
    foreach (tile_map_model[i]) tile_map_model[i] = 1'b0;
    phase_ts = '{16, 1, 64, 127, 0, 8, 3, 16};
    phase_mw = '{64, 4096, 1, 8191, 0, 32, 130, 64};

    // empty map after reset, then extreme boxes
    add_row(known(mk_item(OP_HORIZ, 0, 0, 0, 0, 16, 16, 1), 0, 0, 0));
    add_row(known(mk_item(OP_GROUND, 4095, 1, 16383, 16383, 1024, 1024, 0),
                  0, 16383, 16383));
    add_row(known(mk_item(OP_VERT, 4095, 1, 16383, 16383, 2047, 2047, 1),
                  0, 16383, 16383));
    // corner tiles and one inner tile
    add_row(mk_item(OP_WRITE, 0, 1, 0, 0, 0, 0, 0));
    add_row(mk_item(OP_WRITE, 4095, 1, 16383, 16383, 2047, 2047, 1));
    add_row(mk_item(OP_WRITE, 65, 1, 0, 0, 0, 0, 0));
    // each direction on each axis
    add_row(mk_item(OP_HORIZ, 0, 0, 0, 16, 32, 16, 1));
    add_row(mk_item(OP_HORIZ, 0, 0, 20, 20, 1, 1, 0));
    add_row(mk_item(OP_VERT, 0, 0, 16, 0, 1, 20, 1));
    add_row(mk_item(OP_VERT, 0, 0, 0, 5, 1, 1, 0));
    add_row(mk_item(OP_GROUND, 0, 0, 16, 0, 1, 16, 0));
    // zero box size counts as one pixel
    add_row(mk_item(OP_GROUND, 0, 0, 16, 15, 0, 0, 0));
    add_row(mk_item(OP_HORIZ, 0, 0, 31, 16, 0, 1, 1));
    add_row(mk_item(OP_VERT, 0, 0, 1008, 1000, 16, 16, 1));
    // a column past the map edge must not wrap into the next row
    add_row(mk_item(OP_WRITE, 64, 1, 0, 0, 0, 0, 0));
    add_row(known(mk_item(OP_HORIZ, 0, 0, 1024, 0, 1, 1, 0), 0, 1024, 0));
    add_row(mk_item(OP_WRITE, 0, 0, 0, 0, 0, 0, 0));
    // big tiles, one column: saturation high and a negative correction
    add_row(mk_cfg(REG_TILE_SIZE, 127));
    add_row(mk_cfg(REG_MAP_WIDTH, 1));
    add_row(mk_item(OP_WRITE, 129, 1, 0, 0, 0, 0, 0));
    add_row(known(mk_item(OP_VERT, 0, 0, 0, 16383, 1, 1, 0), 1, 0, 16383));
    add_row(mk_item(OP_WRITE, 0, 1, 0, 0, 0, 0, 0));
    add_row(mk_item(OP_HORIZ, 0, 0, 0, 0, 100, 1, 1));
    // zero tile size acts as one, zero map width never hits
    add_row(mk_cfg(REG_TILE_SIZE, 0));
    add_row(mk_item(OP_HORIZ, 0, 0, 0, 0, 1, 1, 0));
    add_row(mk_cfg(REG_MAP_WIDTH, 0));
    add_row(known(mk_item(OP_HORIZ, 0, 0, 0, 0, 1, 1, 0), 0, 0, 0));

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
      end else begin
        push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // random phases over several register settings
    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_reg(REG_TILE_SIZE, phase_ts[p]);
      write_reg(REG_MAP_WIDTH, phase_mw[p]);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) quiet = ($urandom_range(0, 4) == 0);
        push_item(gen_item(), 1'b0, none);
      end
    end

    // drain
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("[tile_grid_box_collision] OK");
    end else begin
      $display("[tile_grid_box_collision] ERROR");
    end
    $finish;
  end

endmodule
